[hdl/assert_macros.svh]
// Assertion macros used by the port checker in hdl/vatf_checker.sv.
// Clocked on clk, disabled by rst where noted; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// State right after a reset cycle.
`define ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

[hdl/vatf_pkg.sv]
// Types, format codes and divider constants for the vertex attribute converter.
// No dependencies.
`timescale 1ns / 1ps
package vatf_pkg;

  localparam logic [2:0] FMT_UBYTE   = 3'd0;
  localparam logic [2:0] FMT_SNORM16 = 3'd1;
  localparam logic [2:0] FMT_FLOAT   = 3'd2;
  localparam logic [2:0] FMT_SINT16  = 3'd3;
  localparam logic [2:0] FMT_PACKED  = 3'd4;

  localparam logic [2:0]  MAX_COUNT    = 3'd4;
  localparam int          NUM_LANES    = 4;
  localparam logic [31:0] BITS_ONE     = 32'h3F80_0000;
  localparam logic [31:0] BITS_NEG_ONE = 32'hBF80_0000;

  localparam int MANT_W      = 16;
  localparam int RECIP_W     = 42;
  localparam int HALF_W      = 21;
  localparam int PROD_W      = MANT_W + HALF_W;
  localparam int SUM_W       = MANT_W + RECIP_W;
  localparam int RECIP_SHIFT = 31;
  localparam int Q_W         = SUM_W - RECIP_SHIFT;

  // Reciprocals ceil(2^(K+31)/D), K chosen so the quotient lands in [2^25, 2^27).
  localparam logic [63:0] RECIP_255   = ((64'd1 << 49) + 64'd254) / 64'd255;
  localparam logic [63:0] RECIP_32767 = ((64'd1 << 56) + 64'd32766) / 64'd32767;
  localparam logic [63:0] RECIP_1023  = ((64'd1 << 51) + 64'd1022) / 64'd1023;
  localparam logic [63:0] RECIP_511   = ((64'd1 << 50) + 64'd510) / 64'd511;

  typedef enum logic [1:0] {DIV_255, DIV_32767, DIV_1023, DIV_511} div_sel_t;
  typedef enum logic [1:0] {LANE_WORD, LANE_DIV, LANE_INT} lane_kind_t;

  typedef struct packed {
    lane_kind_t        kind;
    logic              neg;
    div_sel_t          div_sel;
    logic [3:0]        lz;
    logic [MANT_W-1:0] mant;
    logic [31:0]       word;
  } lane_op_t;

  typedef struct packed {
    lane_op_t [NUM_LANES-1:0] lane;
    logic                     bad;
  } queue_item_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  component_count;
    logic [63:0] data_low;
    logic [63:0] data_high;
  } item_t;

  typedef struct packed {
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic [31:0] value_z;
    logic [31:0] value_w;
    logic        bad_format;
  } result_t;

  function automatic logic [RECIP_W-1:0] recip(div_sel_t sel);
    logic [63:0] r;
    unique case (sel)
      DIV_255:   r = RECIP_255;
      DIV_32767: r = RECIP_32767;
      DIV_1023:  r = RECIP_1023;
      DIV_511:   r = RECIP_511;
      default:   r = RECIP_255;
    endcase
    return r[RECIP_W-1:0];
  endfunction

  // 127 + 25 - K for each divisor
  function automatic logic [7:0] exp_base(div_sel_t sel);
    logic [7:0] e;
    unique case (sel)
      DIV_255:   e = 8'd134;
      DIV_32767: e = 8'd127;
      DIV_1023:  e = 8'd132;
      DIV_511:   e = 8'd133;
      default:   e = 8'd134;
    endcase
    return e;
  endfunction

  function automatic lane_op_t word_op(logic [31:0] w);
    lane_op_t op;
    op      = '0;
    op.kind = LANE_WORD;
    op.word = w;
    return op;
  endfunction

  // Normalize a nonzero magnitude so its top bit is set.
  function automatic lane_op_t make_lane(lane_kind_t kind, logic neg,
                                         logic [MANT_W-1:0] mag, div_sel_t sel);
    lane_op_t   op;
    logic [3:0] lz;
    lz = '0;
    for (int b = 0; b < MANT_W; b++) begin
      if (mag[b]) lz = 4'(MANT_W - 1 - b);
    end
    op         = '0;
    op.kind    = kind;
    op.neg     = neg;
    op.div_sel = sel;
    op.lz      = lz;
    op.mant    = mag << lz;
    if (mag == '0) op = word_op('0);
    return op;
  endfunction

endpackage

[hdl/vatf_queue.sv]
// Small register queue between the classify front and the convert back.
// Depends on vatf_pkg.
`timescale 1ns / 1ps
module vatf_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  vatf_pkg::queue_item_t  din,
  output logic                   full,
  input  logic                   pop,
  output logic                   valid,
  output vatf_pkg::queue_item_t  dout
);
  import vatf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_item_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[hdl/vatf_front.sv]
// Front end: input register and per-lane classification into lane operations.
// Depends on vatf_pkg.
`timescale 1ns / 1ps
module vatf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  vatf_pkg::item_t        item,
  output logic                   q_push,
  input  logic                   q_full,
  output vatf_pkg::queue_item_t  q_data
);
  import vatf_pkg::*;

  logic  held_valid;
  item_t held;
  logic [2:0] cnt;
  wire lane_op_t [NUM_LANES-1:0] lane_w;

  assign item_stall = held_valid && q_full;
  assign q_push     = held_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) held <= item;
  end

  assign cnt = (held.component_count > MAX_COUNT) ? MAX_COUNT : held.component_count;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    logic              act;
    logic [31:0]       dflt;
    logic [15:0]       s16;
    logic [15:0]       s16_mag;
    logic [31:0]       fword;
    lane_op_t          packed_op;
    lane_op_t          lane_q;

    assign act     = (3'(i) < cnt);
    assign dflt    = (i == NUM_LANES - 1) ? BITS_ONE : 32'd0;
    assign s16     = held.data_low[16*i +: 16];
    assign s16_mag = s16[15] ? (~s16 + 16'd1) : s16;

    if (i < 2) begin : g_flo
      assign fword = held.data_low[32*i +: 32];
    end else begin : g_fhi
      assign fword = held.data_high[32*(i-2) +: 32];
    end

    if (i == 2) begin : g_pz
      logic [9:0] f;
      logic [9:0] fm;
      assign f  = held.data_low[31:22];
      assign fm = f[9] ? (~f + 10'd1) : f;
      assign packed_op = (f == 10'h200) ? word_op(BITS_NEG_ONE)
                       : make_lane(LANE_DIV, f[9], {6'd0, fm}, DIV_511);
    end else if (i < 2) begin : g_pxy
      logic [10:0] f;
      logic [10:0] fm;
      assign f  = held.data_low[11*i +: 11];
      assign fm = f[10] ? (~f + 11'd1) : f;
      assign packed_op = (f == 11'h400) ? word_op(BITS_NEG_ONE)
                       : make_lane(LANE_DIV, f[10], {5'd0, fm}, DIV_1023);
    end else begin : g_pw
      assign packed_op = word_op(dflt);
    end

    always_comb begin
      lane_q = word_op(dflt);
      unique case (held.opcode)
        FMT_UBYTE: begin
          if (act) lane_q = make_lane(LANE_DIV, 1'b0, {8'd0, held.data_low[8*i +: 8]}, DIV_255);
        end
        FMT_SNORM16: begin
          if (act) lane_q = (s16 == 16'h8000) ? word_op(BITS_NEG_ONE)
                          : make_lane(LANE_DIV, s16[15], s16_mag, DIV_32767);
        end
        FMT_FLOAT: begin
          if (act) lane_q = word_op(fword);
        end
        FMT_SINT16: begin
          if (act) lane_q = make_lane(LANE_INT, s16[15], s16_mag, DIV_255);
        end
        FMT_PACKED: begin
          lane_q = packed_op;
        end
        default: ;
      endcase
    end

    assign lane_w[i] = lane_q;
  end

  assign q_data = {lane_w, (held.opcode > FMT_PACKED)};

endmodule

[hdl/vatf_back.sv]
// Back end: reciprocal multiply, normalize, round and pack into IEEE singles.
// Depends on vatf_pkg.
`timescale 1ns / 1ps
module vatf_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  vatf_pkg::queue_item_t  q_data,
  output logic                   q_pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output vatf_pkg::result_t      result
);
  import vatf_pkg::*;

  logic        adv;
  logic        s1_valid;
  queue_item_t s1_item;
  logic [31:0] lane_val [NUM_LANES];

  assign adv   = !result_valid || !result_stall;
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s1_item <= q_data;
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    logic [RECIP_W-1:0] rc;
    logic [PROD_W-1:0]  prod_hi;
    logic [PROD_W-1:0]  prod_lo;
    logic [SUM_W-1:0]   sum;
    logic [Q_W-1:0]     quo;
    logic               lead;
    logic [22:0]        frac;
    logic               rnd;
    logic [7:0]         ex;
    logic [30:0]        mag_bits;
    logic [31:0]        div_val;
    logic [31:0]        int_val;
    lane_op_t           op;

    assign rc = recip(q_data.lane[i].div_sel);

    always_ff @(posedge clk) begin
      if (adv) begin
        prod_hi <= PROD_W'(q_data.lane[i].mant * rc[RECIP_W-1:HALF_W]);
        prod_lo <= PROD_W'(q_data.lane[i].mant * rc[HALF_W-1:0]);
      end
    end

    assign op       = s1_item.lane[i];
    assign sum      = {prod_hi, {HALF_W{1'b0}}} + SUM_W'(prod_lo);
    assign quo      = sum[SUM_W-1:RECIP_SHIFT];
    assign lead     = quo[Q_W-1];
    assign frac     = lead ? quo[Q_W-2:3] : quo[Q_W-3:2];
    assign rnd      = lead ? quo[2] : quo[1];
    assign ex       = exp_base(op.div_sel) + {7'd0, lead} - {4'd0, op.lz};
    assign mag_bits = {ex, frac} + {30'd0, rnd};
    assign div_val  = {op.neg, mag_bits};
    assign int_val  = {op.neg, 8'(8'd142 - {4'd0, op.lz}), op.mant[MANT_W-2:0], 8'd0};

    always_comb begin
      unique case (op.kind)
        LANE_WORD: lane_val[i] = op.word;
        LANE_DIV:  lane_val[i] = div_val;
        LANE_INT:  lane_val[i] = int_val;
        default:   lane_val[i] = op.word;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.value_x    <= lane_val[0];
      result.value_y    <= lane_val[1];
      result.value_z    <= lane_val[2];
      result.value_w    <= lane_val[3];
      result.bad_format <= s1_item.bad;
    end
  end

endmodule

[hdl/vertex_attribute_to_float_unit.sv]
// Vertex attribute to float converter, top level: front, queue, back.
// An accepted item passes the front register, the queue and the back end.
// Throughput one item per cycle unless result_stall or a full queue holds it;
// set by the front register and the two-stage multiply/pack back end.
// Synchronous active-high reset empties the pipeline and the queue.
`timescale 1ns / 1ps
module vertex_attribute_to_float_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  vatf_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output vatf_pkg::result_t   result
);
  import vatf_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  queue_item_t q_in;
  queue_item_t q_out;

  vatf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_data     (q_in)
  );

  vatf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_out)
  );

  vatf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[hdl/vatf_checker.sv]
// Port-level checks for the converter top level, and the bind that attaches them.
// Depends on vatf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vatf_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input vatf_pkg::result_t result
);
  import vatf_pkg::*;

  `ASSERT_AFTER_RESET(a_reset_empty, !result_valid && !item_stall, "not empty after reset")
  `ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled item changed")
  `ASSERT_SAME(a_bad_default, result_valid && result.bad_format, result.value_x == 32'd0 && result.value_y == 32'd0 && result.value_z == 32'd0 && result.value_w == BITS_ONE, "bad format item not default")

endmodule

bind vertex_attribute_to_float_unit vatf_port_checker u_checker (.*);

[verif/vatf_checker.sv]
// Checker for the vertex attribute converter: watches both channels, predicts
// each result with exact integer rounding and compares field by field.
// Depends on vatf_pkg.
`timescale 1ns / 1ps
module vatf_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  vatf_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  vatf_pkg::result_t result,
  output int                errors,
  output int                pending,
  output int                checked
);
  import vatf_pkg::*;

  result_t expected_results[$];

  // n / d as an IEEE single, round to nearest even; n nonzero gives a normal.
  function automatic logic [31:0] quotient_bits(int n, int d);
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] r;
    int          s;
    logic [7:0]  e;
    mag = (n < 0) ? 64'(-n) : 64'(n);
    if (mag == 0) return 32'h0;
    s = -40;
    q = 0;
    r = 0;
    for (int k = -40; k < 40; k++) begin
      if (k < 0) begin
        q = (mag >> (-k)) / 64'(d);
      end else begin
        q = (mag << k) / 64'(d);
      end
      if (q >= 64'h80_0000 && q < 64'h100_0000 && s == -40) s = k;
    end
    // recompute with exact remainder (s >= 0 for our small integers and d >= 1)
    if (s >= 0) begin
      q = (mag << s) / 64'(d);
      r = (mag << s) % 64'(d);
      if (2 * r > 64'(d) || (2 * r == 64'(d) && q[0])) q = q + 1;
    end else begin
      q = mag >> (-s);
      r = mag & ((64'd1 << (-s)) - 1);
      if (2 * r > (64'd1 << (-s)) || (2 * r == (64'd1 << (-s)) && q[0])) q = q + 1;
    end
    if (q == 64'h100_0000) begin
      q = q >> 1;
      s = s - 1;
    end
    e = 8'(127 + 23 - s);
    return {(n < 0), e, q[22:0]};
  endfunction

  function automatic logic [31:0] scaled_clamped(int n, int d);
    if (n < -d) return BITS_NEG_ONE;
    return quotient_bits(n, d);
  endfunction

  function automatic result_t convert_attribute(item_t it);
    logic [31:0] comp[4];
    int          cnt;
    logic [15:0] h;
    logic [31:0] w;
    result_t     res;
    comp[0] = 0;
    comp[1] = 0;
    comp[2] = 0;
    comp[3] = BITS_ONE;
    cnt = (it.component_count > MAX_COUNT) ? 4 : int'(it.component_count);
    res.bad_format = 1'b0;
    case (it.opcode)
      FMT_UBYTE:
        for (int i = 0; i < cnt; i++) comp[i] = quotient_bits(int'(it.data_low[8*i +: 8]), 255);
      FMT_SNORM16:
        for (int i = 0; i < cnt; i++) begin
          h = it.data_low[16*i +: 16];
          comp[i] = scaled_clamped(int'($signed(h)), 32767);
        end
      FMT_FLOAT:
        for (int i = 0; i < cnt; i++)
          comp[i] = (i < 2) ? it.data_low[32*i +: 32] : it.data_high[32*(i-2) +: 32];
      FMT_SINT16:
        for (int i = 0; i < cnt; i++) begin
          h = it.data_low[16*i +: 16];
          comp[i] = quotient_bits(int'($signed(h)), 1);
        end
      FMT_PACKED: begin
        w = it.data_low[31:0];
        comp[0] = scaled_clamped(int'($signed(w[10:0])), 1023);
        comp[1] = scaled_clamped(int'($signed(w[21:11])), 1023);
        comp[2] = scaled_clamped(int'($signed(w[31:22])), 511);
      end
      default: res.bad_format = 1'b1;
    endcase
    res.value_x = comp[0];
    res.value_y = comp[1];
    res.value_z = comp[2];
    res.value_w = comp[3];
    return res;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      expected_results.delete();
      errors  <= 0;
      pending <= 0;
      checked <= 0;
    end else begin
      if (item_valid && !item_stall) expected_results.push_back(convert_attribute(item));
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, result);
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          checked <= checked + 1;
          if (exp_r !== result) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h w=%h bad=%b", $time,
                     exp_r.value_x, exp_r.value_y, exp_r.value_z, exp_r.value_w,
                     exp_r.bad_format);
            $display("%0t:          actual   x=%h y=%h z=%h w=%h bad=%b", $time,
                     result.value_x, result.value_y, result.value_z, result.value_w,
                     result.bad_format);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_results.size();
    end
  end
endmodule

[verif/vertex_attribute_to_float_unit_tb.sv]
// Testbench top for vertex_attribute_to_float_unit: directed and random items
// with random idling on both channels. Depends on vatf_pkg and vatf_checker.
`timescale 1ns / 1ps
module vertex_attribute_to_float_unit_tb;
  import vatf_pkg::*;

  localparam logic [2:0] FMT_BAD_FIRST = 3'd5;
  localparam logic [2:0] FMT_BAD_LAST  = 3'd7;
  localparam int         NUM_RANDOM    = 1130;
  localparam int         IDLE_LIMIT    = 2000;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      errors;
  int      pending;
  int      checked;
  int      idle_cycles;
  int      stall_left;
  int      sent;
  logic    no_idle;

  vertex_attribute_to_float_unit u_top (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  vatf_checker u_checker (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else begin
      result_stall <= 1'b0;
      if (result_valid && !result_stall && !no_idle) stall_left <= $urandom_range(11, 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("vertex_attribute_to_float_unit_tb: errors");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_data();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(9, 0))
      0: d = '0;
      1: d = '1;
      2: d = 64'h8000_8000_8000_8000;
      3: d = 64'h7FFF_7FFF_7FFF_7FFF;
      4: d = {32'h0, 32'h8020_0400};
      5: d = {32'h7FC0_0001, 32'hFF80_0000};
      default: ;
    endcase
    return d;
  endfunction

  task automatic send(logic [2:0] op, logic [2:0] cnt, logic [63:0] lo, logic [63:0] hi);
    int gap;
    gap = no_idle ? 0 : $urandom_range(11, 0);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{opcode: op, component_count: cnt, data_low: lo, data_high: hi};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  initial begin
    logic [2:0] op;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    no_idle    = 1'b0;
    sent       = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(FMT_UBYTE,   3'd4, 64'hFF00_80FF, '0);
    send(FMT_UBYTE,   3'd0, '1, '1);
    send(FMT_UBYTE,   3'd7, 64'h0102_FE01, '0);
    send(FMT_SNORM16, 3'd4, 64'h8000_8001_7FFF_0000, '0);
    send(FMT_SNORM16, 3'd2, 64'hFFFF_0001, '0);
    send(FMT_FLOAT,   3'd4, {32'h7FC0_0001, 32'hFF80_0000}, {32'h8000_0000, 32'h7F80_0001});
    send(FMT_FLOAT,   3'd3, '1, '1);
    send(FMT_FLOAT,   3'd6, 64'h3F80_0000_BF80_0000, 64'h0000_0001_FFFF_FFFF);
    send(FMT_SINT16,  3'd4, 64'h8000_7FFF_FFFF_0001, '0);
    send(FMT_SINT16,  3'd1, 64'h0000_8000, '0);
    send(FMT_PACKED,  3'd0, {32'hFFFF_FFFF, 32'h8020_0400}, '1);
    send(FMT_PACKED,  3'd4, {32'h0, 32'h7FDF_FBFF}, '0);
    send(FMT_PACKED,  3'd7, '1, '0);
    send(FMT_PACKED,  3'd1, '0, '0);
    send(FMT_BAD_FIRST, 3'd4, '1, '1);
    send(3'd6,        3'd2, 64'h1234, '0);
    send(FMT_BAD_LAST, 3'd7, '1, '1);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) begin
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      no_idle = (i % 300) >= 240;
      op = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
      send(op, 3'($urandom_range(7, 0)), rand_data(), rand_data());
    end
    item_valid <= 1'b0;
    no_idle = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d items over all five formats plus invalid codes, counts 0..7;", sent);
    $display("%0d results compared with random idling on both channels.", checked);
    if (errors == 0) begin
      $display("vertex_attribute_to_float_unit_tb: clean");
    end else begin
      $display("vertex_attribute_to_float_unit_tb: errors");
    end
    $finish;
  end
endmodule
